FILE: design/gcd_pkg.sv
// Shared types, constants and CORDIC step functions for the great circle distance block.
// Depends on nothing; every other design file imports it.
`default_nettype none

package gcd_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int ANG_FRAC        = 24;
  localparam int ANG_SHIFT       = ANG_FRAC - COORD_FRAC_BITS;
  localparam int LAT_W           = 24;
  localparam int LON_W           = 25;
  localparam int RAW_W           = LON_W + 1;
  localparam int ANG_W           = 34;
  localparam int Q30_W           = 32;
  localparam int DIST_W          = 18;

  localparam int CORDIC_ITERS    = 24;
  localparam int ITERS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;
  localparam int SQRT_STEPS      = 31;
  localparam int RAD_W           = 62;
  localparam int ROOT_W          = 31;

  localparam int SINCOS_LAT  = CORDIC_STAGES + 2;
  localparam int COMBINE_LAT = 3;
  localparam int ACOS_LAT    = 2 + SQRT_STEPS + 1 + CORDIC_STAGES + 1;
  localparam int SCALE_LAT   = 3;
  localparam int LATENCY     = 1 + SINCOS_LAT + COMBINE_LAT + ACOS_LAT + SCALE_LAT;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [ANG_W-1:0] vec_t;
  typedef logic signed [Q30_W-1:0] q30_t;
  typedef logic        [RAD_W-1:0] rad_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t z;
  } cordic_t;

  localparam logic signed [RAW_W-1:0] RAW180 = RAW_W'(64'sd180 <<< COORD_FRAC_BITS);
  localparam logic signed [RAW_W-1:0] RAW360 = RAW_W'(64'sd360 <<< COORD_FRAC_BITS);
  localparam ang_t DEG90  = ang_t'(64'sd90 <<< ANG_FRAC);
  localparam ang_t DEG180 = ang_t'(64'sd180 <<< ANG_FRAC);

  localparam vec_t CORDIC_GAIN = vec_t'(64'sd652032874);
  localparam q30_t Q30_ONE     = q30_t'(64'sd1 <<< 30);
  localparam logic signed [63:0] Q30_HALF = 64'sd1 <<< 29;
  localparam rad_t RAD_ONE     = rad_t'(64'd1 << 60);

  // miles = angle * 6906 / 104857600, the divisor split as 2^22 * 25
  localparam logic [12:0] MILES_NUM   = 13'd6906;
  localparam logic [44:0] MILES_HALF  = 45'd52428800;
  localparam int          MILES_SHIFT = 22;
  localparam logic [22:0] DIV25_MUL   = 23'd5368710;
  localparam int          DIV25_SHIFT = 27;
  localparam logic [DIST_W-1:0] DIST_MAX = 18'd198893;

  function automatic ang_t atan_q24(input int unsigned i);
    ang_t a;
    case (i)
      0:       a = 34'sd754974720;
      1:       a = 34'sd445687602;
      2:       a = 34'sd235489088;
      3:       a = 34'sd119537938;
      4:       a = 34'sd60000934;
      5:       a = 34'sd30029717;
      6:       a = 34'sd15018523;
      7:       a = 34'sd7509720;
      8:       a = 34'sd3754917;
      9:       a = 34'sd1877466;
      10:      a = 34'sd938734;
      11:      a = 34'sd469367;
      12:      a = 34'sd234684;
      13:      a = 34'sd117342;
      14:      a = 34'sd58671;
      15:      a = 34'sd29335;
      16:      a = 34'sd14668;
      17:      a = 34'sd7334;
      18:      a = 34'sd3667;
      19:      a = 34'sd1833;
      20:      a = 34'sd917;
      21:      a = 34'sd458;
      22:      a = 34'sd229;
      23:      a = 34'sd115;
      default: a = '0;
    endcase
    return a;
  endfunction

  // rotation step: drive z toward zero
  function automatic cordic_t rot_step(input cordic_t a, input int unsigned i);
    cordic_t r;
    vec_t    xv;
    vec_t    yv;
    ang_t    zv;
    xv = a.x;
    yv = a.y;
    zv = a.z;
    if (!zv[ANG_W-1]) begin
      r.x = xv - (yv >>> i);
      r.y = yv + (xv >>> i);
      r.z = zv - atan_q24(i);
    end else begin
      r.x = xv + (yv >>> i);
      r.y = yv - (xv >>> i);
      r.z = zv + atan_q24(i);
    end
    return r;
  endfunction

  // vectoring step: drive y toward zero, accumulate angle in z
  function automatic cordic_t vec_step(input cordic_t a, input int unsigned i);
    cordic_t r;
    vec_t    xv;
    vec_t    yv;
    ang_t    zv;
    xv = a.x;
    yv = a.y;
    zv = a.z;
    if (!yv[ANG_W-1] && (yv != '0)) begin
      r.x = xv + (yv >>> i);
      r.y = yv - (xv >>> i);
      r.z = zv + atan_q24(i);
    end else begin
      r.x = xv - (yv >>> i);
      r.y = yv + (xv >>> i);
      r.z = zv - atan_q24(i);
    end
    return r;
  endfunction

  // round a Q60 product back to Q30, half up
  function automatic q30_t rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + Q30_HALF) >>> 30;
    return t[Q30_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/gcd_sincos.sv
// Pipelined rotation CORDIC giving Q30 sine and cosine of a Q24 degree angle.
// Depends on gcd_pkg.
`default_nettype none

module gcd_sincos (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  gcd_pkg::ang_t angle_i,
  output logic          valid_o,
  output gcd_pkg::q30_t sin_o,
  output gcd_pkg::q30_t cos_o
);
  import gcd_pkg::*;

  ang_t    r_d;
  logic    flip_d;
  cordic_t st_q [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] flip_q;
  logic [CORDIC_STAGES:0] vld_q;
  vec_t    cos_d;
  q30_t    sin_q;
  q30_t    cos_q;
  logic    valid_q;

  // fold into [-90, 90], remember to negate the cosine
  always_comb begin
    r_d    = angle_i;
    flip_d = 1'b0;
    if (angle_i > DEG90) begin
      r_d    = DEG180 - angle_i;
      flip_d = 1'b1;
    end else if (angle_i < -DEG90) begin
      r_d    = -DEG180 - angle_i;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0]   <= {CORDIC_GAIN, vec_t'(0), r_d};
    flip_q[0] <= flip_d;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    cordic_t nxt;
    always_comb begin
      cordic_t v;
      v = st_q[g];
      for (int k = 0; k < ITERS_PER_STAGE; k++) begin
        v = rot_step(v, g * ITERS_PER_STAGE + k);
      end
      nxt = v;
    end
    always_ff @(posedge clk_i) begin
      st_q[g+1]   <= nxt;
      flip_q[g+1] <= flip_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      vld_q   <= {vld_q[CORDIC_STAGES-1:0], valid_i};
      valid_q <= vld_q[CORDIC_STAGES];
    end
  end

  assign cos_d = flip_q[CORDIC_STAGES] ? -st_q[CORDIC_STAGES].x : st_q[CORDIC_STAGES].x;

  always_ff @(posedge clk_i) begin
    sin_q <= st_q[CORDIC_STAGES].y[Q30_W-1:0];
    cos_q <= cos_d[Q30_W-1:0];
  end

  assign valid_o = valid_q;
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

endmodule

`default_nettype wire

FILE: design/gcd_combine.sv
// Forms sin(a)sin(b) + cos(a)cos(b)cos(d) in Q30 and clamps it to [-1, 1].
// Depends on gcd_pkg.
`default_nettype none

module gcd_combine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  gcd_pkg::q30_t sin_a_i,
  input  gcd_pkg::q30_t cos_a_i,
  input  gcd_pkg::q30_t sin_b_i,
  input  gcd_pkg::q30_t cos_b_i,
  input  gcd_pkg::q30_t cos_d_i,
  output logic          valid_o,
  output gcd_pkg::q30_t cosc_o
);
  import gcd_pkg::*;

  logic signed [63:0] p1_q;
  logic signed [63:0] p2_q;
  q30_t               cd_q;
  q30_t               m1_q;
  logic signed [63:0] p3_q;
  logic signed [Q30_W:0] sum_d;
  q30_t               cosc_q;
  logic [2:0]         vld_q;

  always_ff @(posedge clk_i) begin
    p1_q <= sin_a_i * sin_b_i;
    p2_q <= cos_a_i * cos_b_i;
    cd_q <= cos_d_i;
    m1_q <= rnd_q30(p1_q);
    p3_q <= rnd_q30(p2_q) * cd_q;
  end

  assign sum_d = (Q30_W+1)'(m1_q) + (Q30_W+1)'(rnd_q30(p3_q));

  always_ff @(posedge clk_i) begin
    if (sum_d > (Q30_W+1)'(Q30_ONE)) begin
      cosc_q <= Q30_ONE;
    end else if (sum_d < -(Q30_W+1)'(Q30_ONE)) begin
      cosc_q <= -Q30_ONE;
    end else begin
      cosc_q <= sum_d[Q30_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign cosc_o  = cosc_q;

endmodule

`default_nettype wire

FILE: design/gcd_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a side tag.
// Depends on gcd_pkg.
`default_nettype none

module gcd_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  gcd_pkg::rad_t                 rad_i,
  input  gcd_pkg::q30_t                 tag_i,
  output logic                          valid_o,
  output logic [gcd_pkg::ROOT_W-1:0]    root_o,
  output gcd_pkg::q30_t                 tag_o
);
  import gcd_pkg::*;

  rad_t rem_q [SQRT_STEPS];
  rad_t res_q [SQRT_STEPS];
  q30_t tag_q [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] vld_q;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    localparam int K = SQRT_STEPS - 1 - g;
    rad_t rem_in;
    rad_t res_in;
    q30_t tag_in;
    rad_t bitv;
    rad_t trial;

    if (g == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign res_in = res_q[g-1];
      assign tag_in = tag_q[g-1];
    end

    assign bitv  = rad_t'(1) << (2 * K);
    assign trial = res_in + bitv;

    always_ff @(posedge clk_i) begin
      if (rem_in >= trial) begin
        rem_q[g] <= rem_in - trial;
        res_q[g] <= (res_in >> 1) + bitv;
      end else begin
        rem_q[g] <= rem_in;
        res_q[g] <= res_in >> 1;
      end
      tag_q[g] <= tag_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SQRT_STEPS-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[SQRT_STEPS-1];
  assign root_o  = res_q[SQRT_STEPS-1][ROOT_W-1:0];
  assign tag_o   = tag_q[SQRT_STEPS-1];

endmodule

`default_nettype wire

FILE: design/gcd_acos.sv
// Arccosine of a Q30 value as a Q24 degree angle: square root then vectoring CORDIC.
// Depends on gcd_pkg and gcd_isqrt.
`default_nettype none

module gcd_acos (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  gcd_pkg::q30_t cosc_i,
  output logic          valid_o,
  output gcd_pkg::ang_t angle_o
);
  import gcd_pkg::*;

  logic signed [63:0] sq_q;
  q30_t               c1_q;
  rad_t               rad_q;
  q30_t               c2_q;
  logic [1:0]         pre_vld_q;
  logic               sq_valid;
  logic [ROOT_W-1:0]  root;
  q30_t               c3;
  vec_t               root_v;
  vec_t               c_v;
  cordic_t            init_d;
  cordic_t            st_q [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] vld_q;
  ang_t               angle_q;
  logic               valid_q;

  always_ff @(posedge clk_i) begin
    sq_q  <= cosc_i * cosc_i;
    c1_q  <= cosc_i;
    rad_q <= RAD_ONE - sq_q[RAD_W-1:0];
    c2_q  <= c1_q;
  end

  gcd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pre_vld_q[1]),
    .rad_i   (rad_q),
    .tag_i   (c2_q),
    .valid_o (sq_valid),
    .root_o  (root),
    .tag_o   (c3)
  );

  assign root_v = vec_t'({{(ANG_W-ROOT_W){1'b0}}, root});
  assign c_v    = vec_t'(c3);

  // a negative cosine starts from the vector turned by -90 degrees
  always_comb begin
    if (c3[Q30_W-1]) begin
      init_d = {root_v, -c_v, DEG90};
    end else begin
      init_d = {c_v, root_v, ang_t'(0)};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= init_d;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    cordic_t nxt;
    always_comb begin
      cordic_t v;
      v = st_q[g];
      for (int k = 0; k < ITERS_PER_STAGE; k++) begin
        v = vec_step(v, g * ITERS_PER_STAGE + k);
      end
      nxt = v;
    end
    always_ff @(posedge clk_i) begin
      st_q[g+1] <= nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= st_q[CORDIC_STAGES].z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
      vld_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      pre_vld_q <= {pre_vld_q[0], valid_i};
      vld_q     <= {vld_q[CORDIC_STAGES-1:0], sq_valid};
      valid_q   <= vld_q[CORDIC_STAGES];
    end
  end

  assign valid_o = valid_q;
  assign angle_o = angle_q;

endmodule

`default_nettype wire

FILE: design/great_circle_distance.sv
// Great circle distance (spherical law of cosines), fully pipelined top level.
// Takes one word per cycle; done_o flags each finished result.
// busy stays low: a new word may be started every cycle, results never back up.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// Depends on gcd_pkg, gcd_sincos, gcd_combine, gcd_acos.
`default_nettype none

module great_circle_distance (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [gcd_pkg::LAT_W-1:0]  lat_a_i,
  input  logic signed [gcd_pkg::LON_W-1:0]  lon_a_i,
  input  logic signed [gcd_pkg::LAT_W-1:0]  lat_b_i,
  input  logic signed [gcd_pkg::LON_W-1:0]  lon_b_i,
  output logic                              done_o,
  output logic [gcd_pkg::DIST_W-1:0]        distance_miles_o
);
  import gcd_pkg::*;

  // wrap an angle into [-180, 180) degrees and rescale it to Q24
  function automatic ang_t wrap_q24(input logic signed [RAW_W-1:0] v);
    logic signed [RAW_W-1:0] r;
    r = v;
    if (r >= RAW180) begin
      r = r - RAW360;
    end else if (r < -RAW180) begin
      r = r + RAW360;
    end
    return ang_t'(r) <<< ANG_SHIFT;
  endfunction

  logic                    accept;
  logic signed [RAW_W-1:0] lon_diff;
  ang_t                    la_q;
  ang_t                    lb_q;
  ang_t                    ld_q;
  logic                    in_vld_q;

  logic sc_valid;
  q30_t sin_a, cos_a, sin_b, cos_b, cos_d;
  logic cb_valid;
  q30_t cosc;
  logic ac_valid;
  ang_t angle;

  logic [31:0]  ang_clamp;
  logic [44:0]  prod_q;
  logic [44:0]  rounded;
  logic [45:0]  quot_q;
  logic [DIST_W-1:0] dist_q;
  logic [1:0]   sc_vld_q;
  logic         done_q;

  // no stall source anywhere in the pipe
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign lon_diff = RAW_W'(lon_b_i) - RAW_W'(lon_a_i);

  // Stage 0: range-reduce the three angles
  always_ff @(posedge clk_i) begin
    la_q <= wrap_q24(RAW_W'(lat_a_i));
    lb_q <= wrap_q24(RAW_W'(lat_b_i));
    ld_q <= wrap_q24(lon_diff);
  end

  // three parallel CORDIC pipes run in lockstep; one valid stands for all
  gcd_sincos u_sincos_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .angle_i (la_q),
    .valid_o (sc_valid),
    .sin_o   (sin_a),
    .cos_o   (cos_a)
  );

  gcd_sincos u_sincos_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .angle_i (lb_q),
    .valid_o (),
    .sin_o   (sin_b),
    .cos_o   (cos_b)
  );

  gcd_sincos u_sincos_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .angle_i (ld_q),
    .valid_o (),
    .sin_o   (),
    .cos_o   (cos_d)
  );

  gcd_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_valid),
    .sin_a_i (sin_a),
    .cos_a_i (cos_a),
    .sin_b_i (sin_b),
    .cos_b_i (cos_b),
    .cos_d_i (cos_d),
    .valid_o (cb_valid),
    .cosc_o  (cosc)
  );

  gcd_acos u_acos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cb_valid),
    .cosc_i  (cosc),
    .valid_o (ac_valid),
    .angle_o (angle)
  );

  // Clamp the central angle to [0, 180] degrees
  always_comb begin
    if (angle[ANG_W-1]) begin
      ang_clamp = '0;
    end else if (angle > DEG180) begin
      ang_clamp = DEG180[31:0];
    end else begin
      ang_clamp = angle[31:0];
    end
  end

  // Scale: angle * 6906, round, shift by 2^22, then divide by 25 via reciprocal
  assign rounded = prod_q + MILES_HALF;

  always_ff @(posedge clk_i) begin
    prod_q <= ang_clamp * MILES_NUM;
    quot_q <= rounded[44:MILES_SHIFT] * DIV25_MUL;
    dist_q <= quot_q[DIV25_SHIFT+DIST_W-1:DIV25_SHIFT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      sc_vld_q <= '0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= accept;
      sc_vld_q <= {sc_vld_q[0], ac_valid};
      done_q   <= sc_vld_q[1];
    end
  end

  assign done_o           = done_q;
  assign distance_miles_o = dist_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("result strobe missing after accepted word");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result strobe without an accepted word");

  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (distance_miles_o <= DIST_MAX))
    else $error("distance beyond half a circumference");
`endif

endmodule

`default_nettype wire
